>>> hw/rtl/bf3_pkg.sv
package bf3_pkg;

	localparam int MAX_SIDE_DEF     = 1024;
	localparam int CHANNEL_BITS_DEF = 16;

	// fixed field widths of the ports
	localparam int FIELD_W = 16;
	localparam int POS_W   = 10;
	localparam int CFG_W   = 11;

	// positions wrap at this count, frame side never exceeds it
	localparam int POS_RANGE      = 1024;
	localparam int MIN_SIDE       = 2;
	localparam int FRAME_SIZE_RST = 512;

	// divisor of the clipped window
	typedef logic [1:0] cnt_code_t;
	localparam cnt_code_t CNT_NINE = 2'd0;
	localparam cnt_code_t CNT_SIX  = 2'd1;
	localparam cnt_code_t CNT_FOUR = 2'd2;

endpackage

>>> hw/rtl/bf3_mean.sv
module bf3_mean #(
	parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    load,
	input  bf3_pkg::cnt_code_t      code,
	input  logic [CHANNEL_BITS+3:0] sum  [3],
	output logic [CHANNEL_BITS-1:0] mean [3]
);

	// floor(x / d) = (x * ceil(2^K / d)) >> K for every window sum
	localparam int K     = CHANNEL_BITS + 8;
	localparam int MW    = K - 1;
	localparam int SUM_W = CHANNEL_BITS + 4;
	localparam int PW    = SUM_W + MW;

	localparam longint unsigned ONE_K = 64'd1 << K;
	localparam logic [MW-1:0] M_FOUR = MW'(ONE_K / 4);
	localparam logic [MW-1:0] M_SIX  = MW'((ONE_K + 64'd5) / 6);
	localparam logic [MW-1:0] M_NINE = MW'((ONE_K + 64'd8) / 9);

	logic [MW-1:0] mult;
	logic [PW-1:0] prod_s4 [3];

	always_comb begin
		case (code)
			bf3_pkg::CNT_NINE: mult = M_NINE;
			bf3_pkg::CNT_SIX:  mult = M_SIX;
			bf3_pkg::CNT_FOUR: mult = M_FOUR;
			default:           mult = M_FOUR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_s4[ch] <= PW'(sum[ch]) * PW'(mult);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			mean[ch] = prod_s4[ch][K+CHANNEL_BITS-1:K];
		end
	end

endmodule

>>> hw/rtl/box_filter_3x3_rgb.sv
// channel  handshake              payload
// in       in_valid / in_ready    red_in, green_in, blue_in
// out      out_valid / out_ready  red_out, green_out, blue_out, out_row, out_col, frame_done
// cfg      cfg_valid / cfg_ready  cfg_data (frame side, clamped to 2 .. min(MAX_SIDE, 1024))
//
// one pixel a cycle is taken while the stages ahead are not held; each pixel stays in the emission
// stage until it has released its results: end-of-row pixels below row 0 and last-row pixels past
// column 0 release two results, the last pixel of a frame four.
// a pixel passes stages 1, 2 and 3 before its first result reaches the output register.
// reset clears counters, window and pipeline valids; line store is not cleared.
// out_ready low backs up through the stages to in_ready; cfg_ready is always high.
module box_filter_3x3_rgb #(
	parameter int MAX_SIDE     = bf3_pkg::MAX_SIDE_DEF,
	parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bf3_pkg::FIELD_W-1:0] red_in,
	input  logic [bf3_pkg::FIELD_W-1:0] green_in,
	input  logic [bf3_pkg::FIELD_W-1:0] blue_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bf3_pkg::FIELD_W-1:0] red_out,
	output logic [bf3_pkg::FIELD_W-1:0] green_out,
	output logic [bf3_pkg::FIELD_W-1:0] blue_out,
	output logic [bf3_pkg::POS_W-1:0]   out_row,
	output logic [bf3_pkg::POS_W-1:0]   out_col,
	output logic                        frame_done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bf3_pkg::CFG_W-1:0]   cfg_data
);

	localparam int POS_W      = bf3_pkg::POS_W;
	localparam int CFG_W      = bf3_pkg::CFG_W;
	localparam int LINE_DEPTH = MAX_SIDE < bf3_pkg::POS_RANGE ? MAX_SIDE : bf3_pkg::POS_RANGE;
	localparam int LA         = $clog2(LINE_DEPTH);
	localparam int CB         = CHANNEL_BITS;
	localparam int PIXW       = 3 * CB;
	localparam int SUM_W      = CB + 4;
	localparam int SIZE_RST   = bf3_pkg::FRAME_SIZE_RST < LINE_DEPTH ?
	                            bf3_pkg::FRAME_SIZE_RST : LINE_DEPTH;
	localparam logic [POS_W-1:0] LAST_RST = POS_W'(SIZE_RST - 1);

	// release codes, one bit each, lowest goes out first
	localparam logic [3:0] REL_UP_LEFT = 4'b0001;
	localparam logic [3:0] REL_UP      = 4'b0010;
	localparam logic [3:0] REL_LEFT    = 4'b0100;
	localparam logic [3:0] REL_SELF    = 4'b1000;

	typedef struct packed {
		logic [3:0]       pend;
		logic             top_x;
		logic             left_x;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} job_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} res_info_t;

	logic [POS_W-1:0] row_q, col_q, last_q;
	logic [CFG_W-1:0] cfg_size;
	logic             in_acc;
	logic             row_ge1, col_ge1, col_end, row_end;
	job_t             job_s0;

	logic             v1_q, adv1;
	job_t             job_s1;
	logic [PIXW-1:0]  pix_s1;
	logic [2*PIXW-1:0] line_rd_s1;
	logic [2*PIXW-1:0] line_mem [LINE_DEPTH];

	logic [PIXW-1:0]  window_q [9];

	logic             v2_q, done2, emit_go;
	job_t             job_s2;
	logic [3:0]       low;
	logic             sel_top_x, sel_left_x;
	res_info_t        sel_info;
	logic [SUM_W-1:0] sum_next [3];
	bf3_pkg::cnt_code_t code_next;

	logic             v3_q, adv3, free3;
	logic [SUM_W-1:0] sum_s3 [3];
	bf3_pkg::cnt_code_t code_s3;
	res_info_t        info_s3;

	logic             v4_q;
	res_info_t        info_s4;
	logic [CB-1:0]    mean [3];

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid & in_ready;

	always_comb begin
		if (cfg_data < CFG_W'(bf3_pkg::MIN_SIDE)) begin
			cfg_size = CFG_W'(bf3_pkg::MIN_SIDE);
		end else if (cfg_data > CFG_W'(LINE_DEPTH)) begin
			cfg_size = CFG_W'(LINE_DEPTH);
		end else begin
			cfg_size = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			last_q <= LAST_RST;
		end else if (cfg_valid) begin
			row_q  <= '0;
			col_q  <= '0;
			last_q <= POS_W'(cfg_size - CFG_W'(1));
		end else if (in_acc) begin
			if (col_q == last_q) begin
				col_q <= '0;
				row_q <= (row_q == last_q) ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	// which results this pixel releases, and how its windows are clipped
	always_comb begin
		row_ge1 = row_q != '0;
		col_ge1 = col_q != '0;
		col_end = col_q == last_q;
		row_end = row_q == last_q;
		job_s0.pend = ((row_ge1 & col_ge1) ? REL_UP_LEFT : 4'b0) |
		              ((row_ge1 & col_end) ? REL_UP : 4'b0) |
		              ((row_end & col_ge1) ? REL_LEFT : 4'b0) |
		              ((row_end & col_end) ? REL_SELF : 4'b0);
		job_s0.top_x  = row_q < POS_W'(2);
		job_s0.left_x = col_q < POS_W'(2);
		job_s0.row    = row_q;
		job_s0.col    = col_q;
	end

	// stage 1: line read data arrives, write-back and window shift on advance.
	// consecutive pixels hit different columns and the write lands before the next
	// read of the same column, so no forwarding is needed
	assign in_ready = !v1_q | adv1;
	assign adv1     = v1_q & (!v2_q | done2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (in_acc) begin
			v1_q <= 1'b1;
		end else if (adv1) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			job_s1 <= job_s0;
			pix_s1 <= {blue_in[CB-1:0], green_in[CB-1:0], red_in[CB-1:0]};
		end
	end

	// entry holds {upper, middle}
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_rd_s1 <= line_mem[col_q[LA-1:0]];
		end
		if (adv1) begin
			line_mem[job_s1.col[LA-1:0]] <= {line_rd_s1[PIXW-1:0], pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
		end else if (adv1) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r*3]   <= window_q[r*3+1];
				window_q[r*3+1] <= window_q[r*3+2];
			end
			window_q[2] <= line_rd_s1[2*PIXW-1:PIXW];
			window_q[5] <= line_rd_s1[PIXW-1:0];
			window_q[8] <= pix_s1;
		end
	end

	// stage 2: one result per cycle out of the current window while stage 3 is free
	assign free3   = !v3_q | adv3;
	assign low     = job_s2.pend & (~job_s2.pend + 4'd1);
	assign emit_go = v2_q & (job_s2.pend != 4'b0) & free3;
	assign done2   = v2_q & ((job_s2.pend == 4'b0) | (emit_go & (job_s2.pend == low)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv1) begin
			v2_q <= 1'b1;
		end else if (done2) begin
			v2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			job_s2 <= job_s1;
		end else if (emit_go) begin
			job_s2.pend <= job_s2.pend & ~low;
		end
	end

	always_comb begin
		sel_info.done = 1'b0;
		case (low)
			REL_UP_LEFT: begin
				sel_top_x    = job_s2.top_x;
				sel_left_x   = job_s2.left_x;
				sel_info.row = job_s2.row - POS_W'(1);
				sel_info.col = job_s2.col - POS_W'(1);
			end
			REL_UP: begin
				sel_top_x    = job_s2.top_x;
				sel_left_x   = 1'b1;
				sel_info.row = job_s2.row - POS_W'(1);
				sel_info.col = job_s2.col;
			end
			REL_LEFT: begin
				sel_top_x    = 1'b1;
				sel_left_x   = job_s2.left_x;
				sel_info.row = job_s2.row;
				sel_info.col = job_s2.col - POS_W'(1);
			end
			REL_SELF: begin
				sel_top_x     = 1'b1;
				sel_left_x    = 1'b1;
				sel_info.row  = job_s2.row;
				sel_info.col  = job_s2.col;
				sel_info.done = 1'b1;
			end
			default: begin
				sel_top_x    = 1'b1;
				sel_left_x   = 1'b1;
				sel_info.row = job_s2.row;
				sel_info.col = job_s2.col;
			end
		endcase
	end

	// clipped cells are muxed out, never-written line entries only land there
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_next[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (!((r == 0) && sel_top_x) && !((c == 0) && sel_left_x)) begin
						sum_next[ch] = sum_next[ch] + SUM_W'(window_q[r*3+c][ch*CB +: CB]);
					end
				end
			end
		end
		if (sel_top_x && sel_left_x) begin
			code_next = bf3_pkg::CNT_FOUR;
		end else if (sel_top_x || sel_left_x) begin
			code_next = bf3_pkg::CNT_SIX;
		end else begin
			code_next = bf3_pkg::CNT_NINE;
		end
	end

	// stage 3: sums, stage 4: means in the output register
	assign adv3 = v3_q & (!v4_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (emit_go) begin
				v3_q <= 1'b1;
			end else if (adv3) begin
				v3_q <= 1'b0;
			end
			if (adv3) begin
				v4_q <= 1'b1;
			end else if (out_ready) begin
				v4_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			sum_s3  <= sum_next;
			code_s3 <= code_next;
			info_s3 <= sel_info;
		end
		if (adv3) begin
			info_s4 <= info_s3;
		end
	end

	bf3_mean #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_mean (
		.clk (clk),
		.load(adv3),
		.code(code_s3),
		.sum (sum_s3),
		.mean(mean)
	);

	assign out_valid  = v4_q;
	assign red_out    = bf3_pkg::FIELD_W'(mean[0]);
	assign green_out  = bf3_pkg::FIELD_W'(mean[1]);
	assign blue_out   = bf3_pkg::FIELD_W'(mean[2]);
	assign out_row    = info_s4.row;
	assign out_col    = info_s4.col;
	assign frame_done = info_s4.done;

endmodule
